### rtl/lps_pkg.sv
// Shared types and constants for the loop period statistics block.
`timescale 1ns / 1ps
package lps_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int PERIOD_BITS_DEF = 32;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 32;
    localparam int IN_DATA_BITS    = 32;
    localparam int OUT_DATA_BITS   = 264;
    localparam int MEAN_BITS       = 48;
    localparam int VAR_BITS        = 64;
    localparam int DEV_BITS        = 40;
    localparam int EXT_BITS        = 32;
    localparam int AT_BITS         = 24;
    localparam int CNT_REG_BITS    = 24;
    localparam int DIV_STEPS       = 64;
    localparam int MUL1_STEPS      = 48;
    localparam int SQRT_STEPS      = 36;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NOMINAL_PERIOD = 8'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ARM,
        OP_LOAD,
        OP_DIV_STEP,
        OP_MEAN_DONE,
        OP_VAR_DONE,
        OP_MUL_STEP,
        OP_MUL1_DONE,
        OP_VAR_UPD,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_SQRT_DONE,
        OP_INC,
        OP_EMIT
    } lps_op_t;

    typedef struct packed {
        lps_op_t op;
        logic    done;
    } lps_cmd_t;

    typedef struct packed {
        logic sample_ok;
        logic last_sample;
        logic out_busy;
    } lps_status_t;

endpackage

### rtl/lps_ctrl.sv
// Sequencing state machine for the loop period statistics block.
`timescale 1ns / 1ps
module lps_ctrl
    import lps_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        in_arm,
    input  lps_status_t status,
    output logic        in_ready,
    output lps_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ARM, S_LOAD, S_DIVM, S_MDONE, S_DIVV, S_VDONE, S_MUL1,
        S_M1DONE, S_MUL2, S_VUPD, S_SQLOAD, S_SQRT, S_SQDONE, S_INC, S_EMIT
    } state_t;

    localparam logic [6:0] DIV_LAST  = 7'(DIV_STEPS - 1);
    localparam logic [6:0] MUL1_LAST = 7'(MUL1_STEPS - 1);
    localparam logic [6:0] MUL2_LAST = 7'(COUNT_BITS);
    localparam logic [6:0] SQRT_LAST = 7'(SQRT_STEPS - 1);

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;
    logic       cnt_zero;

    assign cnt_zero = (cnt_reg == 7'd0);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_zero ? cnt_reg : cnt_reg - 7'd1;
        done_next  = done_reg;
        cmd.op     = OP_NONE;
        cmd.done   = done_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    done_next = 1'b0;
                    if (in_arm)
                        state_next = S_ARM;
                    else if (status.sample_ok)
                        state_next = S_LOAD;
                    else
                        state_next = S_EMIT;
                end
            end
            S_ARM:
            begin
                cmd.op     = OP_ARM;
                state_next = S_EMIT;
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                cnt_next   = DIV_LAST;
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.op = OP_DIV_STEP;
                if (cnt_zero)
                    state_next = S_MDONE;
            end
            S_MDONE:
            begin
                cmd.op     = OP_MEAN_DONE;
                cnt_next   = DIV_LAST;
                state_next = S_DIVV;
            end
            S_DIVV:
            begin
                cmd.op = OP_DIV_STEP;
                if (cnt_zero)
                    state_next = S_VDONE;
            end
            S_VDONE:
            begin
                cmd.op     = OP_VAR_DONE;
                cnt_next   = MUL1_LAST;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op = OP_MUL_STEP;
                if (cnt_zero)
                    state_next = S_M1DONE;
            end
            S_M1DONE:
            begin
                cmd.op     = OP_MUL1_DONE;
                cnt_next   = MUL2_LAST;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op = OP_MUL_STEP;
                if (cnt_zero)
                    state_next = S_VUPD;
            end
            S_VUPD:
            begin
                cmd.op     = OP_VAR_UPD;
                state_next = status.last_sample ? S_SQLOAD : S_INC;
            end
            S_SQLOAD:
            begin
                cmd.op     = OP_SQRT_LOAD;
                cnt_next   = SQRT_LAST;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (cnt_zero)
                    state_next = S_SQDONE;
            end
            S_SQDONE:
            begin
                cmd.op     = OP_SQRT_DONE;
                done_next  = 1'b1;
                state_next = S_INC;
            end
            S_INC:
            begin
                cmd.op     = OP_INC;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

endmodule

### rtl/lps_datapath.sv
// Statistics state, shared divider, multiplier and square root, result register.
`timescale 1ns / 1ps
module lps_datapath
    import lps_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_fire,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_fire,
    input  logic [IN_DATA_BITS-1:0]   in_period,
    input  lps_cmd_t                  cmd,
    input  logic                      out_ready,
    output lps_status_t               status,
    output logic                      out_valid,
    output logic [OUT_DATA_BITS-1:0]  out_data,
    output logic                      out_active,
    output logic                      out_done
);

    localparam int CB = COUNT_BITS;
    localparam int PB = PERIOD_BITS;

    // configuration
    logic [CNT_REG_BITS-1:0] count_reg;
    logic [PB-1:0]           nom_reg;

    // run state
    logic                running_reg;
    logic [CB-1:0]       idx_reg;
    logic [MEAN_BITS-1:0] mean_reg;
    logic [VAR_BITS-1:0] var_reg;
    logic [PB-1:0]       max_reg, min_reg;
    logic [CB-1:0]       maxi_reg, mini_reg;
    logic [DEV_BITS-1:0] fdev_reg;

    // work registers
    logic [PB-1:0]        t_reg;
    logic                 neg_reg;
    logic [71:0]          num_reg;
    logic [39:0]          rem_reg;
    logic [32:0]          div_reg;
    logic [MEAN_BITS-1:0] d_reg;
    logic [VAR_BITS-1:0]  term1_reg;
    logic [127:0]         mcand_reg, prod_reg;
    logic [47:0]          mult_reg;

    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic                     out_active_reg, out_done_reg;

    logic                 active;
    logic [CB:0]          k;
    logic [MEAN_BITS-1:0] t16, diff;
    logic [39:0]          rem_sh, sq_sh, sq_trial;
    logic [63:0]          rlo;
    logic [64:0]          vsum;
    logic [31:0]          maxi_w, mini_w;

    assign active = running_reg && ({1'b0, 32'(idx_reg)} <= {9'b0, count_reg});
    assign k      = {1'b0, idx_reg} + {{CB{1'b0}}, 1'b1};
    assign t16    = MEAN_BITS'(t_reg) << 16;
    assign diff   = (t16 >= mean_reg) ? t16 - mean_reg : mean_reg - t16;
    assign rem_sh = {rem_reg[38:0], num_reg[63]};
    assign sq_sh  = {rem_reg[37:0], num_reg[71:70]};
    assign sq_trial = {2'b0, d_reg[35:0], 2'b01};
    assign rlo    = (prod_reg[127:88] != 40'd0) ? {VAR_BITS{1'b1}} : prod_reg[87:24];
    assign vsum   = {1'b0, term1_reg} + {1'b0, rlo};
    assign maxi_w = 32'(maxi_reg);
    assign mini_w = 32'(mini_reg);

    assign status.sample_ok   = active;
    assign status.last_sample = ({1'b0, 32'(idx_reg)} == {9'b0, count_reg});
    assign status.out_busy    = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_active = out_active_reg;
    assign out_done   = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= CNT_REG_BITS'(1000);
            nom_reg        <= '0;
            running_reg    <= 1'b0;
            idx_reg        <= CB'(1);
            mean_reg       <= '0;
            var_reg        <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            maxi_reg       <= '0;
            mini_reg       <= '0;
            fdev_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                if (cfg_index == REG_SAMPLE_COUNT)
                    count_reg <= cfg_data[CNT_REG_BITS-1:0];
                else if (cfg_index == REG_NOMINAL_PERIOD)
                    nom_reg <= cfg_data[PB-1:0];
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_ARM:
                begin
                    running_reg <= 1'b1;
                    idx_reg     <= CB'(1);
                    mean_reg    <= MEAN_BITS'(nom_reg) << 16;
                    var_reg     <= '0;
                    max_reg     <= nom_reg;
                    min_reg     <= nom_reg;
                    maxi_reg    <= '0;
                    mini_reg    <= '0;
                    fdev_reg    <= '0;
                end
                OP_LOAD:
                begin
                    if (t_reg > max_reg)
                    begin
                        max_reg  <= t_reg;
                        maxi_reg <= idx_reg;
                    end
                    if (t_reg < min_reg)
                    begin
                        min_reg  <= t_reg;
                        mini_reg <= idx_reg;
                    end
                end
                OP_MEAN_DONE:
                begin
                    mean_reg <= neg_reg ? mean_reg - num_reg[MEAN_BITS-1:0]
                                        : mean_reg + num_reg[MEAN_BITS-1:0];
                end
                OP_VAR_UPD:
                begin
                    var_reg <= vsum[64] ? {VAR_BITS{1'b1}} : vsum[63:0];
                end
                OP_SQRT_DONE:
                begin
                    fdev_reg    <= DEV_BITS'(d_reg[35:0]);
                    running_reg <= 1'b0;
                end
                OP_INC:
                begin
                    idx_reg <= idx_reg + CB'(1);
                end
                OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // work registers and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            t_reg <= in_period[PB-1:0];
        case (cmd.op)
            OP_LOAD:
            begin
                neg_reg <= (t16 < mean_reg);
                num_reg <= 72'(diff);
                rem_reg <= '0;
                div_reg <= 33'(k);
            end
            OP_DIV_STEP:
            begin
                if (rem_sh >= {7'b0, div_reg})
                begin
                    rem_reg <= rem_sh - {7'b0, div_reg};
                    num_reg <= {8'b0, num_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    num_reg <= {8'b0, num_reg[62:0], 1'b0};
                end
            end
            OP_MEAN_DONE:
            begin
                d_reg   <= num_reg[MEAN_BITS-1:0];
                num_reg <= {8'b0, var_reg};
                rem_reg <= '0;
                div_reg <= 33'(idx_reg);
            end
            OP_VAR_DONE:
            begin
                term1_reg <= ({1'b0, 32'(idx_reg)} <= 33'd1) ? '0
                             : var_reg - num_reg[63:0];
                mcand_reg <= 128'(d_reg);
                mult_reg  <= d_reg;
                prod_reg  <= '0;
            end
            OP_MUL_STEP:
            begin
                if (mult_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg <= {mcand_reg[126:0], 1'b0};
                mult_reg  <= {1'b0, mult_reg[47:1]};
            end
            OP_MUL1_DONE:
            begin
                mcand_reg <= prod_reg;
                mult_reg  <= 48'(k);
                prod_reg  <= '0;
            end
            OP_SQRT_LOAD:
            begin
                num_reg <= {var_reg, 8'b0};
                rem_reg <= '0;
                d_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                num_reg <= {num_reg[69:0], 2'b0};
                if (sq_sh >= sq_trial)
                begin
                    rem_reg <= sq_sh - sq_trial;
                    d_reg   <= {d_reg[MEAN_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= sq_sh;
                    d_reg   <= {d_reg[MEAN_BITS-2:0], 1'b0};
                end
            end
            OP_EMIT:
            begin
                out_data_reg   <= {mini_w[AT_BITS-1:0], EXT_BITS'(min_reg),
                                   maxi_w[AT_BITS-1:0], EXT_BITS'(max_reg),
                                   fdev_reg, var_reg, mean_reg};
                out_active_reg <= active;
                out_done_reg   <= cmd.done;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/loop_period_statistics.sv
// Top level of the loop period statistics block: controller plus datapath.
//
// Channel        Dir  Signals                                   Payload
// s_axis         in   s_axis_tvalid/tready/tdata/tuser          period, req_type
// m_axis         out  m_axis_tvalid/tready/tdata/tuser/tlast    statistics result
// cfg            in   cfg_valid/ready/index/data                register writes
//
// One transaction at a time. An arm passes through the arm and emit states; an ignored
// sample goes straight to emit. An accepted sample runs 2*64 divider steps (mean, then
// variance) on the shift-and-subtract divider and 48 + COUNT_BITS+1 steps on the
// shift-and-add multiplier, between load, done, update, increment and emit states; the
// final sample of a run adds 36 square-root steps between a load and a done state.
// Reset clears the run state and loads sample_count 1000, nominal_period 0.
// A waiting result holds in the output register; the block takes the next
// transaction meanwhile and stalls only when a second result is ready.
`timescale 1ns / 1ps
module loop_period_statistics
    import lps_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel (always ready)
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,  // [31:0] period
    input  logic                      s_axis_tuser,  // [0] req_type (1 = arm)
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [47:0] mean_period, [111:48] variance, [151:112] deviation,
    // [183:152] longest, [207:184] longest_at, [239:208] shortest,
    // [263:240] shortest_at
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                      m_axis_tuser,  // [0] active
    output logic                      m_axis_tlast   // done_res
);

    lps_cmd_t    cmd;
    lps_status_t status;
    logic        in_fire;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    lps_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_arm   (s_axis_tuser),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    lps_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_fire   (cfg_fire),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .in_period  (s_axis_tdata),
        .cmd        (cmd),
        .out_ready  (m_axis_tready),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .out_active (m_axis_tuser),
        .out_done   (m_axis_tlast)
    );

endmodule
